/* sv/chip8_instruction_core_macros.svh */
`ifndef CHIP8_INSTRUCTION_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define C8IC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled in reset.
`define C8IC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/c8ic_pkg.sv */
package c8ic_pkg;

   localparam int DEF_MEM_BYTES     = 4096;
   localparam int DEF_SCREEN_WIDTH  = 64;
   localparam int DEF_SCREEN_HEIGHT = 32;
   localparam int DEF_STACK_ENTRIES = 16;
   localparam int NUM_DATA_REGS     = 16;

   localparam logic [11:0] START_RESET = 12'h200;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_EXEC  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNKNOWN   = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_OVERFLOW  = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [11:0] address;
      logic [7:0]  data_byte;
      logic [4:0]  row_index;
   } req_type;

   typedef struct packed {
      logic [11:0] program_counter;
      logic [15:0] last_instruction;
      logic [1:0]  status;
      logic [63:0] display_row;
      logic        display_changed;
      logic        sound_on;
   } rsp_type;

endpackage

/* sv/c8ic_engine.sv */
`include "chip8_instruction_core_macros.svh"

module c8ic_engine #(
   parameter int MEM_BYTES     = c8ic_pkg::DEF_MEM_BYTES,
   parameter int SCREEN_WIDTH  = c8ic_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = c8ic_pkg::DEF_SCREEN_HEIGHT,
   parameter int STACK_ENTRIES = c8ic_pkg::DEF_STACK_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  c8ic_pkg::req_type req_in,
   input  logic              csr_write,
   input  logic [11:0]       csr_data,
   output logic              idle,
   output logic              res_valid,
   input  logic              res_ready,
   output c8ic_pkg::rsp_type res_out
);

   localparam int AW  = $clog2(MEM_BYTES);
   localparam int FW  = $clog2(SCREEN_HEIGHT);
   localparam int XW  = $clog2(SCREEN_WIDTH);
   localparam int SIW = $clog2(STACK_ENTRIES);
   localparam int SPW = $clog2(STACK_ENTRIES + 1);
   localparam int VW  = $clog2(c8ic_pkg::NUM_DATA_REGS);
   localparam int RowPad   = 64 - SCREEN_WIDTH;
   localparam int MemRecip = (1 << 24) / MEM_BYTES;
   localparam int WRecip   = (1 << 16) / SCREEN_WIDTH;
   localparam int HRecip   = (1 << 16) / SCREEN_HEIGHT;

   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_JP   = 4'h1;
   localparam logic [3:0] OP_CALL = 4'h2;
   localparam logic [3:0] OP_SE   = 4'h3;
   localparam logic [3:0] OP_SNE  = 4'h4;
   localparam logic [3:0] OP_SER  = 4'h5;
   localparam logic [3:0] OP_LD   = 4'h6;
   localparam logic [3:0] OP_ADD  = 4'h7;
   localparam logic [3:0] OP_ALU  = 4'h8;
   localparam logic [3:0] OP_SNER = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_DRW  = 4'hD;
   localparam logic [3:0] OP_MISC = 4'hF;

   localparam logic [15:0] W_CLS = 16'h00E0;
   localparam logic [15:0] W_RET = 16'h00EE;

   localparam logic [7:0] FX_GET_DT = 8'h07;
   localparam logic [7:0] FX_SET_DT = 8'h15;
   localparam logic [7:0] FX_SET_ST = 8'h18;
   localparam logic [7:0] FX_ADD_I  = 8'h1E;
   localparam logic [7:0] FX_FONT   = 8'h29;
   localparam logic [7:0] FX_BCD    = 8'h33;
   localparam logic [7:0] FX_STORE  = 8'h55;
   localparam logic [7:0] FX_LOAD   = 8'h65;

   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_RSB = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ROW, S_F1, S_F2, S_VX, S_VY, S_EXEC, S_RET, S_FLAG,
      S_CLS, S_DRAW_RD, S_DRAW_WR, S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR,
      S_FINISH
   } state_type;

   // Reduces a byte address modulo the memory size: reciprocal estimate,
   // then at most one correcting subtraction.
   function automatic logic [AW-1:0] mem_addr(input logic [16:0] a);
      logic [32:0] prod;
      logic [31:0] rem;
      prod = 33'(a) * 33'(MemRecip);
      rem  = 32'(a) - 32'(prod[32:24]) * 32'(MEM_BYTES);
      if (rem >= 32'(MEM_BYTES)) begin
         rem = rem - 32'(MEM_BYTES);
      end
      return AW'(rem);
   endfunction

   function automatic logic [XW-1:0] pos_x(input logic [7:0] v);
      logic [23:0] prod;
      logic [15:0] rem;
      prod = 24'(v) * 24'(WRecip);
      rem  = 16'(v) - 16'(prod[23:16]) * 16'(SCREEN_WIDTH);
      if (rem >= 16'(SCREEN_WIDTH)) begin
         rem = rem - 16'(SCREEN_WIDTH);
      end
      return XW'(rem);
   endfunction

   function automatic logic [FW-1:0] pos_y(input logic [7:0] v);
      logic [23:0] prod;
      logic [15:0] rem;
      prod = 24'(v) * 24'(HRecip);
      rem  = 16'(v) - 16'(prod[23:16]) * 16'(SCREEN_HEIGHT);
      if (rem >= 16'(SCREEN_HEIGHT)) begin
         rem = rem - 16'(SCREEN_HEIGHT);
      end
      return FW'(rem);
   endfunction

   // Decimal digit of an 8-bit value: 0 hundreds, 1 tens, 2 ones.
   function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [3:0] sel);
      logic [1:0]  hund;
      logic [7:0]  r;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [7:0]  ones;
      hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
      r    = v - 8'(hund) * 8'd100;
      prod = 15'(r) * 15'd205;
      tens = prod[14:11];
      ones = r - 8'(tens) * 8'd10;
      if (sel == 4'd0) begin
         return 8'(hund);
      end else if (sel == 4'd1) begin
         return 8'(tens);
      end
      return ones;
   endfunction

   logic [7:0]              prog_mem  [MEM_BYTES];
   logic [7:0]              vreg_mem  [c8ic_pkg::NUM_DATA_REGS];
   logic [SCREEN_WIDTH-1:0] frame_mem [SCREEN_HEIGHT];
   logic [11:0]             stack_mem [STACK_ENTRIES];

   logic                    pm_we;
   logic [AW-1:0]           pm_wa, pm_ra;
   logic [7:0]              pm_wd;
   logic [7:0]              pm_q_ff;
   logic                    v_we;
   logic [VW-1:0]           v_wa, v_ra;
   logic [7:0]              v_wd;
   logic [7:0]              v_q_ff;
   logic                    f_we;
   logic [FW-1:0]           f_wa, f_ra;
   logic [SCREEN_WIDTH-1:0] f_wd;
   logic [SCREEN_WIDTH-1:0] f_q_ff;
   logic                    s_we;
   logic [SIW-1:0]          s_wa, s_ra;
   logic [11:0]             s_wd;
   logic [11:0]             s_q_ff;

   always_ff @(posedge clock) begin
      if (pm_we) begin
         prog_mem[pm_wa] <= pm_wd;
      end
      pm_q_ff <= prog_mem[pm_ra];
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         vreg_mem[v_wa] <= v_wd;
      end
      v_q_ff <= vreg_mem[v_ra];
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         frame_mem[f_wa] <= f_wd;
      end
      f_q_ff <= frame_mem[f_ra];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         stack_mem[s_wa] <= s_wd;
      end
      s_q_ff <= stack_mem[s_ra];
   end

   state_type       state_ff, state_in;
   logic [AW-1:0]   cnt_ff, cnt_in;
   logic [3:0]      step_ff, step_in;
   logic [11:0]     pc_ff, pc_in;
   logic [11:0]     start_ff, start_in;
   logic [15:0]     idx_ff, idx_in;
   logic [SPW-1:0]  sp_ff, sp_in;
   logic [7:0]      delay_ff, delay_in;
   logic [7:0]      sound_ff, sound_in;
   logic            flag_ff, flag_in;
   logic [15:0]     word_ff, word_in;
   logic [7:0]      vx_ff, vx_in;
   logic [7:0]      vy_ff, vy_in;
   logic [XW-1:0]   x0_ff, x0_in;
   logic [FW-1:0]   y0_ff, y0_in;
   logic [1:0]      status_ff, status_in;
   logic [63:0]     row_ff, row_in;
   logic            changed_ff, changed_in;

   logic [SPW-1:0]            sp_dec;
   logic [7:0]                draw_y;
   logic [7:0]                next_y;
   logic [SCREEN_WIDTH+7:0]   spr_ext;
   logic [SCREEN_WIDTH-1:0]   mask;
   logic [16:0]               i_step;

   assign sp_dec  = sp_ff - SPW'(1);
   assign draw_y  = 8'(y0_ff) + 8'(step_ff);
   assign next_y  = draw_y + 8'd1;
   assign spr_ext = {pm_q_ff, SCREEN_WIDTH'(0)} >> x0_ff;
   assign mask    = spr_ext[SCREEN_WIDTH+7:8];
   assign i_step  = 17'(idx_ff) + 17'(step_ff);

   always_comb begin
      logic [3:0]  op;
      logic [3:0]  x;
      logic [3:0]  n;
      logic [7:0]  nn;
      logic [8:0]  sum9;
      logic [16:0] sum_i;
      op   = word_ff[15:12];
      x    = word_ff[11:8];
      n    = word_ff[3:0];
      nn   = word_ff[7:0];
      sum9 = 9'(vx_ff) + 9'(vy_ff);
      sum_i = 17'(idx_ff) + 17'(vx_ff);

      state_in   = state_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      pc_in      = pc_ff;
      start_in   = start_ff;
      idx_in     = idx_ff;
      sp_in      = sp_ff;
      delay_in   = delay_ff;
      sound_in   = sound_ff;
      flag_in    = flag_ff;
      word_in    = word_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      x0_in      = x0_ff;
      y0_in      = y0_ff;
      status_in  = status_ff;
      row_in     = row_ff;
      changed_in = changed_ff;

      pm_we = 1'b0;  pm_wa = '0;  pm_wd = '0;  pm_ra = '0;
      v_we  = 1'b0;  v_wa  = '0;  v_wd  = '0;  v_ra  = '0;
      f_we  = 1'b0;  f_wa  = '0;  f_wd  = '0;  f_ra  = '0;
      s_we  = 1'b0;  s_wa  = '0;  s_wd  = '0;  s_ra  = '0;
      res_valid = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            pm_we = 1'b1;
            pm_wa = cnt_ff;
            if (32'(cnt_ff) < 32'(c8ic_pkg::NUM_DATA_REGS)) begin
               v_we = 1'b1;
               v_wa = VW'(cnt_ff);
            end
            if (32'(cnt_ff) < 32'(SCREEN_HEIGHT)) begin
               f_we = 1'b1;
               f_wa = FW'(cnt_ff);
            end
            if (32'(cnt_ff) == 32'(MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               word_in    = '0;
               status_in  = c8ic_pkg::ST_OK;
               row_in     = '0;
               changed_in = 1'b0;
               unique case (req_in.command)
                  c8ic_pkg::CMD_WRITE: begin
                     pm_we    = 1'b1;
                     pm_wa    = mem_addr(17'(req_in.address));
                     pm_wd    = req_in.data_byte;
                     state_in = S_FINISH;
                  end
                  c8ic_pkg::CMD_EXEC: begin
                     pm_ra    = mem_addr(17'(pc_ff));
                     state_in = S_F1;
                  end
                  c8ic_pkg::CMD_TICK: begin
                     if (delay_ff != 8'd0) begin
                        delay_in = delay_ff - 8'd1;
                     end
                     if (sound_ff != 8'd0) begin
                        sound_in = sound_ff - 8'd1;
                     end
                     state_in = S_FINISH;
                  end
                  c8ic_pkg::CMD_READ: begin
                     flag_in  = 7'(req_in.row_index) < 7'(SCREEN_HEIGHT);
                     f_ra     = FW'(req_in.row_index);
                     state_in = S_ROW;
                  end
               endcase
            end
         end
         S_ROW: begin
            row_in   = flag_ff ? (64'(f_q_ff) << RowPad) : 64'd0;
            state_in = S_FINISH;
         end
         S_F1: begin
            word_in[15:8] = pm_q_ff;
            pm_ra         = mem_addr(17'(pc_ff) + 17'd1);
            state_in      = S_F2;
         end
         S_F2: begin
            word_in[7:0] = pm_q_ff;
            pc_in        = pc_ff + 12'd2;
            v_ra         = word_ff[11:8];
            state_in     = S_VX;
         end
         S_VX: begin
            vx_in    = v_q_ff;
            v_ra     = word_ff[7:4];
            state_in = S_VY;
         end
         S_VY: begin
            vy_in    = v_q_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FINISH;
            unique case (op)
               OP_SYS: begin
                  if (word_ff == W_CLS) begin
                     changed_in = 1'b1;
                     cnt_in     = '0;
                     state_in   = S_CLS;
                  end else if (word_ff == W_RET) begin
                     if (sp_ff == '0) begin
                        status_in = c8ic_pkg::ST_UNDERFLOW;
                     end else begin
                        sp_in    = sp_dec;
                        s_ra     = sp_dec[SIW-1:0];
                        state_in = S_RET;
                     end
                  end else begin
                     status_in = c8ic_pkg::ST_UNKNOWN;
                  end
               end
               OP_JP: pc_in = word_ff[11:0];
               OP_CALL: begin
                  if (sp_ff >= SPW'(STACK_ENTRIES)) begin
                     status_in = c8ic_pkg::ST_OVERFLOW;
                  end else begin
                     s_we  = 1'b1;
                     s_wa  = sp_ff[SIW-1:0];
                     s_wd  = pc_ff;
                     sp_in = sp_ff + SPW'(1);
                     pc_in = word_ff[11:0];
                  end
               end
               OP_SE: if (vx_ff == nn) pc_in = pc_ff + 12'd2;
               OP_SNE: if (vx_ff != nn) pc_in = pc_ff + 12'd2;
               OP_SER: if (vx_ff == vy_ff) pc_in = pc_ff + 12'd2;
               OP_SNER: if (vx_ff != vy_ff) pc_in = pc_ff + 12'd2;
               OP_LD: begin
                  v_we = 1'b1;
                  v_wa = x;
                  v_wd = nn;
               end
               OP_ADD: begin
                  v_we = 1'b1;
                  v_wa = x;
                  v_wd = vx_ff + nn;
               end
               OP_ALU: begin
                  v_wa = x;
                  v_we = 1'b1;
                  case (n)
                     ALU_MOV: v_wd = vy_ff;
                     ALU_OR:  v_wd = vx_ff | vy_ff;
                     ALU_AND: v_wd = vx_ff & vy_ff;
                     ALU_XOR: v_wd = vx_ff ^ vy_ff;
                     ALU_ADD: begin
                        v_wd = sum9[7:0];
                        flag_in = sum9[8];
                        state_in = S_FLAG;
                     end
                     ALU_SUB: begin
                        v_wd = vx_ff - vy_ff;
                        flag_in = vx_ff >= vy_ff;
                        state_in = S_FLAG;
                     end
                     ALU_SHR: begin
                        v_wd = vx_ff >> 1;
                        flag_in = vx_ff[0];
                        state_in = S_FLAG;
                     end
                     ALU_RSB: begin
                        v_wd = vy_ff - vx_ff;
                        flag_in = vy_ff >= vx_ff;
                        state_in = S_FLAG;
                     end
                     ALU_SHL: begin
                        v_wd = vx_ff << 1;
                        flag_in = vx_ff[7];
                        state_in = S_FLAG;
                     end
                     default: begin
                        v_we = 1'b0;
                        status_in = c8ic_pkg::ST_UNKNOWN;
                     end
                  endcase
               end
               OP_LDI: idx_in = 16'(word_ff[11:0]);
               OP_DRW: begin
                  changed_in = 1'b1;
                  if (n == 4'd0) begin
                     v_we = 1'b1;
                     v_wa = VW'(c8ic_pkg::NUM_DATA_REGS - 1);
                     v_wd = 8'd0;
                  end else begin
                     x0_in    = pos_x(vx_ff);
                     y0_in    = pos_y(vy_ff);
                     step_in  = '0;
                     flag_in  = 1'b0;
                     state_in = S_DRAW_RD;
                  end
               end
               OP_MISC: begin
                  step_in = '0;
                  case (nn)
                     FX_GET_DT: begin
                        v_we = 1'b1;
                        v_wa = x;
                        v_wd = delay_ff;
                     end
                     FX_SET_DT: delay_in = vx_ff;
                     FX_SET_ST: sound_in = vx_ff;
                     FX_ADD_I: begin
                        idx_in   = sum_i[15:0];
                        flag_in  = sum_i[15:0] > 16'h0FFF;
                        state_in = S_FLAG;
                     end
                     FX_FONT:  idx_in = 16'(vx_ff) * 16'd5;
                     FX_BCD:   state_in = S_BCD;
                     FX_STORE: state_in = S_ST_RD;
                     FX_LOAD:  state_in = S_LD_RD;
                     default:  status_in = c8ic_pkg::ST_UNKNOWN;
                  endcase
               end
               default: status_in = c8ic_pkg::ST_UNKNOWN;
            endcase
         end
         S_RET: begin
            pc_in    = s_q_ff;
            state_in = S_FINISH;
         end
         S_FLAG: begin
            v_we     = 1'b1;
            v_wa     = VW'(c8ic_pkg::NUM_DATA_REGS - 1);
            v_wd     = 8'(flag_ff);
            state_in = S_FINISH;
         end
         S_CLS: begin
            f_we = 1'b1;
            f_wa = FW'(cnt_ff);
            f_wd = '0;
            if (32'(cnt_ff) == 32'(SCREEN_HEIGHT - 1)) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         S_DRAW_RD: begin
            pm_ra    = mem_addr(i_step);
            f_ra     = FW'(draw_y);
            state_in = S_DRAW_WR;
         end
         S_DRAW_WR: begin
            f_we    = 1'b1;
            f_wa    = FW'(draw_y);
            f_wd    = f_q_ff ^ mask;
            flag_in = flag_ff | (|(f_q_ff & mask));
            if ((5'(step_ff) + 5'd1 < 5'(n)) && (next_y < 8'(SCREEN_HEIGHT))) begin
               step_in  = step_ff + 4'd1;
               state_in = S_DRAW_RD;
            end else begin
               state_in = S_FLAG;
            end
         end
         S_BCD: begin
            pm_we = 1'b1;
            pm_wa = mem_addr(i_step);
            pm_wd = bcd_digit(vx_ff, step_ff);
            if (step_ff == 4'd2) begin
               state_in = S_FINISH;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_ST_RD: begin
            v_ra     = step_ff;
            state_in = S_ST_WR;
         end
         S_ST_WR: begin
            pm_we = 1'b1;
            pm_wa = mem_addr(i_step);
            pm_wd = v_q_ff;
            if (step_ff == x) begin
               state_in = S_FINISH;
            end else begin
               step_in  = step_ff + 4'd1;
               state_in = S_ST_RD;
            end
         end
         S_LD_RD: begin
            pm_ra    = mem_addr(i_step);
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            v_we = 1'b1;
            v_wa = step_ff;
            v_wd = pm_q_ff;
            if (step_ff == x) begin
               state_in = S_FINISH;
            end else begin
               step_in  = step_ff + 4'd1;
               state_in = S_LD_RD;
            end
         end
         S_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // The start address also reloads the program counter.
      if (csr_write) begin
         start_in = csr_data;
         pc_in    = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         pc_ff    <= c8ic_pkg::START_RESET;
         start_ff <= c8ic_pkg::START_RESET;
         idx_ff   <= '0;
         sp_ff    <= '0;
         delay_ff <= '0;
         sound_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pc_ff    <= pc_in;
         start_ff <= start_in;
         idx_ff   <= idx_in;
         sp_ff    <= sp_in;
         delay_ff <= delay_in;
         sound_ff <= sound_in;
         flag_ff  <= flag_in;
      end
      step_ff    <= step_in;
      word_ff    <= word_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      x0_ff      <= x0_in;
      y0_ff      <= y0_in;
      status_ff  <= status_in;
      row_ff     <= row_in;
      changed_ff <= changed_in;
   end

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      res_out.program_counter  = pc_ff;
      res_out.last_instruction = word_ff;
      res_out.status           = status_ff;
      res_out.display_row      = row_ff;
      res_out.display_changed  = changed_ff;
      res_out.sound_on         = (sound_ff != 8'd0);
   end

   `C8IC_ASSERT_NOW(a_sp_range, 1'b1, sp_ff <= SPW'(STACK_ENTRIES), "stack depth out of range")
   `C8IC_ASSERT_NEXT(a_finish_hold, (state_ff == S_FINISH) && !res_ready, state_ff == S_FINISH, "result dropped while stalled")
   `C8IC_ASSERT_NEXT(a_jump_pc, (state_ff == S_EXEC) && (word_ff[15:12] == OP_JP) && !csr_write, pc_ff == $past(word_ff[11:0]), "jump target not loaded")

endmodule

/* sv/chip8_instruction_core.sv */
// Instruction core of an 8-bit interpreter machine with 4 KB of byte memory
// and a 64x32 monochrome frame.
// The req channel (valid/stall) carries one command per transaction: write a
// memory byte, execute the instruction at the program counter, apply one
// timer tick, or read one frame row. Every command returns exactly one
// transaction on the rsp channel (valid/stall) with pc, fetched word, status,
// row pixels, display-changed and sound flags.
// The csr channel (valid/ready, always ready) writes the start address and
// reloads the program counter with it.
// After reset a clearing pass zeroes program memory, data registers and the
// frame; req_stall stays high during it.
// Items are processed one at a time. An execute fetches the two instruction
// bytes and reads Vx and Vy; a screen clear then writes each frame row, a
// draw reads and rewrites one frame row per sprite row, and block moves handle
// one register at a time. Memory reads are registered.
// A finished result sits in the rsp output register while the next item is
// taken; if rsp_stall holds it there, the following result waits in the engine.
`include "chip8_instruction_core_macros.svh"

module chip8_instruction_core #(
   parameter int MEM_BYTES     = c8ic_pkg::DEF_MEM_BYTES,
   parameter int SCREEN_WIDTH  = c8ic_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = c8ic_pkg::DEF_SCREEN_HEIGHT,
   parameter int STACK_ENTRIES = c8ic_pkg::DEF_STACK_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  c8ic_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output c8ic_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [11:0]       csr_data
);

   logic              idle;
   logic              req_accept;
   logic              res_valid;
   logic              res_ready;
   c8ic_pkg::rsp_type res_out;
   logic              rsp_valid_ff, rsp_valid_in;
   c8ic_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   assign req_stall  = !idle;
   assign req_accept = req_valid && idle;
   assign csr_ready  = 1'b1;
   assign res_ready  = !rsp_valid_ff || !rsp_stall;

   c8ic_engine #(
      .MEM_BYTES     (MEM_BYTES),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .STACK_ENTRIES (STACK_ENTRIES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_in     (req_payload),
      .csr_write  (csr_valid),
      .csr_data   (csr_data),
      .idle       (idle),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_out    (res_out)
   );

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `C8IC_ASSERT_NEXT(a_handoff, res_valid && res_ready, rsp_valid_ff, "result lost at output register")

endmodule
